FILE: rtl/xbd_pkg.sv
// ============================================================================
// xbd_pkg
// Shared types and constants for the x86 subset byte decoder.
// ============================================================================
package xbd_pkg;

   localparam int REG_COUNT        = 8;
   localparam int REG_W            = 32;
   localparam int REGNUM_W         = 3;
   localparam int LEN_W            = 5;
   localparam int IMM_CNT_W        = 3;
   localparam int MAX_INSTR_BYTES  = 17;

   // Opcodes of the supported subset.
   localparam logic [7:0] OPC_OPSIZE     = 8'h66;
   localparam logic [7:0] OPC_ESCAPE     = 8'h0f;
   localparam logic [7:0] OPC_CPUID      = 8'ha2;
   localparam logic [7:0] OPC_NOP        = 8'h90;
   localparam logic [7:0] OPC_INC_FIRST  = 8'h40;
   localparam logic [7:0] OPC_INC_LAST   = 8'h47;
   localparam logic [7:0] OPC_MOV8_FIRST = 8'hb0;
   localparam logic [7:0] OPC_MOV8_HIGH  = 8'hb4;
   localparam logic [7:0] OPC_MOV8_LAST  = 8'hb7;
   localparam logic [7:0] OPC_MOVW_FIRST = 8'hb8;
   localparam logic [7:0] OPC_MOVW_LAST  = 8'hbf;
   localparam logic [7:0] OPC_CLC        = 8'hf8;
   localparam logic [7:0] OPC_STC        = 8'hf9;
   localparam logic [7:0] OPC_CLI        = 8'hfa;
   localparam logic [7:0] OPC_STI        = 8'hfb;
   localparam logic [7:0] OPC_CLD        = 8'hfc;
   localparam logic [7:0] OPC_STD        = 8'hfd;

   typedef enum logic [1:0] {
      ST_MORE = 2'd0,
      ST_DONE = 2'd1,
      ST_BAD  = 2'd2,
      ST_LONG = 2'd3
   } xbd_status_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SECOND = 2'd1,
      PH_IMM8   = 2'd2,
      PH_IMMW   = 2'd3
   } xbd_phase_type;

   // How the register file entry is modified once its old value is read.
   typedef enum logic [2:0] {
      WOP_INC16   = 3'd0,
      WOP_INC32   = 3'd1,
      WOP_BYTE_LO = 3'd2,
      WOP_BYTE_HI = 3'd3,
      WOP_WORD16  = 3'd4,
      WOP_DWORD   = 3'd5
   } xbd_wop_type;

   typedef struct packed {
      xbd_status_type        status;
      logic [LEN_W-1:0]      instr_len;
      logic                  reg_written;
      logic [REGNUM_W-1:0]   reg_number;
      xbd_wop_type           wop;
      logic [REG_W-1:0]      imm;
      logic                  carry_flag;
      logic                  direction_flag;
      logic                  interrupt_flag;
      logic                  cpuid_request;
   } xbd_stage_type;

endpackage

FILE: rtl/xbd_req_if.sv
// ============================================================================
// xbd_req_if
// Code byte channel: one instruction byte per transaction.
// ============================================================================
interface xbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink   (input valid, input code_byte, output ready);
endinterface

FILE: rtl/xbd_rsp_if.sv
// ============================================================================
// xbd_rsp_if
// Decode result channel: one result per accepted code byte.
// ============================================================================
interface xbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  instr_len;
   logic        reg_written;
   logic [2:0]  reg_number;
   logic [31:0] reg_value;
   logic        carry_flag;
   logic        direction_flag;
   logic        interrupt_flag;
   logic        cpuid_request;

   modport source (output valid, output status, output instr_len, output reg_written,
                   output reg_number, output reg_value, output carry_flag,
                   output direction_flag, output interrupt_flag, output cpuid_request,
                   input ready);
   modport sink   (input valid, input status, input instr_len, input reg_written,
                   input reg_number, input reg_value, input carry_flag,
                   input direction_flag, input interrupt_flag, input cpuid_request,
                   output ready);
endinterface

FILE: rtl/x86_subset_byte_decoder_top.sv
// ============================================================================
// x86_subset_byte_decoder_top
// Byte-serial decoder and executor for a small x86 instruction subset.
// ============================================================================
//
//   channel  | direction | carries
//   ---------+-----------+------------------------------------------------
//   req_bus  | in        | code_byte, one instruction byte per transaction
//   rsp_bus  | out       | status, length, register write, flags, cpuid
//   csr_*    | in        | default operand size (1 = 16-bit), written whenever
//            |           | csr_wr_en is high
//
// One code byte is taken every cycle while req_bus.ready is high. Its result
// passes through the middle stage, which waits on the registered read of the
// register file memory, and on into the output register. Reset is synchronous;
// the register file entries carry valid bits, so no clearing pass is needed.
// A stalled result holds the output register; the middle stage then holds
// too, and one byte more can be taken before req_bus.ready drops.
//
module x86_subset_byte_decoder_top
   import xbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   xbd_req_if.sink      req_bus,
   xbd_rsp_if.source    rsp_bus,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   // ------------------------------------------------------------------------
   // Configuration and decode state.
   // ------------------------------------------------------------------------
   logic                  def16_ff;
   xbd_phase_type         phase_ff, phase_in;
   logic                  size16_ff, size16_in;
   logic [7:0]            held_ff, held_in;
   logic [REG_W-1:0]      acc_ff, acc_in;
   logic [IMM_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]      bc_ff, bc_in;
   logic                  cf_ff, cf_in;
   logic                  df_ff, df_in;
   logic                  if_ff, if_in;

   // Middle stage: decoded byte waiting for its register file read data.
   logic                  s1_valid_ff, s1_valid_in;
   xbd_stage_type         s1_ff, s1_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   xbd_stage_type         out_ff;
   logic [REG_W-1:0]      out_value_ff;

   // Register file bookkeeping: valid bits and last-write forwarding.
   logic [REG_COUNT-1:0]  rf_valid_ff;
   logic                  fwd_valid_ff;
   logic [REGNUM_W-1:0]   fwd_addr_ff;
   logic [REG_W-1:0]      fwd_data_ff;
   logic [REGNUM_W-1:0]   rd_addr_ff;

   logic                  accept;
   logic                  s1_adv;
   logic [7:0]            code;
   logic                  too_long;
   logic                  mode16;
   logic [REG_W-1:0]      acc_step;
   logic [IMM_CNT_W-1:0]  cnt_step;
   logic [IMM_CNT_W-1:0]  need;
   logic                  word_done;
   logic [REGNUM_W-1:0]   rd_addr;
   logic [REG_W-1:0]      rd_data;
   logic [REG_W-1:0]      old_value;
   logic [REG_W-1:0]      new_value;
   logic                  wr_en;

   // ------------------------------------------------------------------------
   // Handshake. The middle stage moves on when the output register is free
   // or is being emptied in the same cycle.
   // ------------------------------------------------------------------------
   assign s1_adv        = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign accept        = req_bus.valid && req_bus.ready;
   assign code          = req_bus.code_byte;

   // A byte that arrives once the length limit is reached is thrown away.
   assign too_long = (bc_ff >= LEN_W'(MAX_INSTR_BYTES));
   // The configured operand size is sampled at the first byte only.
   assign mode16   = (bc_ff == '0) ? def16_ff : size16_ff;

   // Immediate assembly for mov r16/r32, imm, little-endian.
   assign acc_step  = acc_ff | ({{(REG_W-8){1'b0}}, code} << {cnt_ff[1:0], 3'b000});
   assign cnt_step  = cnt_ff + IMM_CNT_W'(1);
   assign need      = size16_ff ? IMM_CNT_W'(2) : IMM_CNT_W'(4);
   assign word_done = (cnt_step >= need);

   // ------------------------------------------------------------------------
   // Next decode phase.
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      if (too_long) begin
         phase_in = PH_IDLE;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (code == OPC_OPSIZE) begin
                  phase_in = PH_IDLE;
               end else if (code == OPC_ESCAPE) begin
                  phase_in = PH_SECOND;
               end else if (code >= OPC_MOV8_FIRST && code <= OPC_MOV8_LAST) begin
                  phase_in = PH_IMM8;
               end else if (code >= OPC_MOVW_FIRST && code <= OPC_MOVW_LAST) begin
                  phase_in = PH_IMMW;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SECOND: phase_in = PH_IDLE;
            PH_IMM8:   phase_in = PH_IDLE;
            PH_IMMW:   phase_in = word_done ? PH_IDLE : PH_IMMW;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Decode of one byte: control updates, flags, and the register file read
   // that the later write-back needs.
   // ------------------------------------------------------------------------
   always_comb begin
      logic done;
      logic bad;
      done      = 1'b0;
      bad       = 1'b0;
      size16_in = size16_ff;
      held_in   = held_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      bc_in     = bc_ff + LEN_W'(1);
      cf_in     = cf_ff;
      df_in     = df_ff;
      if_in     = if_ff;
      rd_addr   = '0;

      s1_in             = '0;
      s1_in.status      = ST_MORE;
      s1_in.wop         = WOP_INC32;

      if (too_long) begin
         s1_in.status = ST_LONG;
         bc_in        = '0;
         acc_in       = '0;
         cnt_in       = '0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (code == OPC_OPSIZE) begin
                  size16_in = ~mode16;
               end else begin
                  size16_in = mode16;
                  held_in   = code;
                  if (code >= OPC_INC_FIRST && code <= OPC_INC_LAST) begin
                     rd_addr           = code[REGNUM_W-1:0];
                     s1_in.reg_written = 1'b1;
                     s1_in.reg_number  = code[REGNUM_W-1:0];
                     s1_in.wop         = mode16 ? WOP_INC16 : WOP_INC32;
                     done              = 1'b1;
                  end else if (code == OPC_NOP) begin
                     done = 1'b1;
                  end else if (code == OPC_ESCAPE) begin
                     done = 1'b0;
                  end else if (code >= OPC_MOV8_FIRST && code <= OPC_MOV8_LAST) begin
                     done = 1'b0;
                  end else if (code >= OPC_MOVW_FIRST && code <= OPC_MOVW_LAST) begin
                     acc_in = '0;
                     cnt_in = '0;
                  end else if (code >= OPC_CLC && code <= OPC_STD) begin
                     unique case (code)
                        OPC_CLC: cf_in = 1'b0;
                        OPC_STC: cf_in = 1'b1;
                        OPC_CLI: if_in = 1'b0;
                        OPC_STI: if_in = 1'b1;
                        OPC_CLD: df_in = 1'b0;
                        OPC_STD: df_in = 1'b1;
                        default: cf_in = cf_ff;
                     endcase
                     done = 1'b1;
                  end else begin
                     bad = 1'b1;
                  end
               end
            end
            PH_SECOND: begin
               if (code == OPC_CPUID) begin
                  s1_in.cpuid_request = 1'b1;
                  done                = 1'b1;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_IMM8: begin
               rd_addr           = {1'b0, held_ff[1:0]};
               s1_in.reg_written = 1'b1;
               s1_in.reg_number  = {1'b0, held_ff[1:0]};
               s1_in.wop         = (held_ff >= OPC_MOV8_HIGH) ? WOP_BYTE_HI : WOP_BYTE_LO;
               s1_in.imm         = {{(REG_W-8){1'b0}}, code};
               done              = 1'b1;
            end
            PH_IMMW: begin
               acc_in  = acc_step;
               cnt_in  = cnt_step;
               rd_addr = held_ff[REGNUM_W-1:0];
               if (word_done) begin
                  s1_in.reg_written = 1'b1;
                  s1_in.reg_number  = held_ff[REGNUM_W-1:0];
                  s1_in.wop         = size16_ff ? WOP_WORD16 : WOP_DWORD;
                  s1_in.imm         = acc_step;
                  done              = 1'b1;
               end
            end
         endcase

         // A finished or rejected instruction starts the next one afresh.
         if (done) begin
            s1_in.status    = ST_DONE;
            s1_in.instr_len = bc_in;
            bc_in           = '0;
            acc_in          = '0;
            cnt_in          = '0;
         end else if (bad) begin
            s1_in.status = ST_BAD;
            bc_in        = '0;
            acc_in       = '0;
            cnt_in       = '0;
         end
      end

      s1_in.carry_flag     = cf_in;
      s1_in.direction_flag = df_in;
      s1_in.interrupt_flag = if_in;
   end

   // ------------------------------------------------------------------------
   // Register file: read when a byte is taken, modify in the middle stage,
   // write back when the result moves to the output register. The read at the
   // write-back edge of the previous byte may return stale data, so the last
   // write is kept and forwarded on an address match.
   // ------------------------------------------------------------------------
   xbd_ram #(
      .WIDTH (REG_W),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.reg_number),
      .wr_data (new_value),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) begin
         old_value = fwd_data_ff;
      end else if (rf_valid_ff[rd_addr_ff]) begin
         old_value = rd_data;
      end else begin
         old_value = '0;
      end
   end

   always_comb begin
      unique case (s1_ff.wop)
         WOP_INC16:   new_value = {old_value[31:16], old_value[15:0] + 16'd1};
         WOP_INC32:   new_value = old_value + REG_W'(1);
         WOP_BYTE_LO: new_value = {old_value[31:8], s1_ff.imm[7:0]};
         WOP_BYTE_HI: new_value = {old_value[31:16], s1_ff.imm[7:0], old_value[7:0]};
         WOP_WORD16:  new_value = {old_value[31:16], s1_ff.imm[15:0]};
         WOP_DWORD:   new_value = s1_ff.imm;
         default:     new_value = old_value;
      endcase
   end

   assign wr_en = s1_adv && s1_ff.reg_written;

   // ------------------------------------------------------------------------
   // Stage valids.
   // ------------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         def16_ff     <= 1'b1;
         phase_ff     <= PH_IDLE;
         size16_ff    <= 1'b1;
         held_ff      <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         bc_ff        <= '0;
         cf_ff        <= 1'b0;
         df_ff        <= 1'b0;
         if_ff        <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            def16_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff  <= phase_in;
            size16_ff <= size16_in;
            held_ff   <= held_in;
            acc_ff    <= acc_in;
            cnt_ff    <= cnt_in;
            bc_ff     <= bc_in;
            cf_ff     <= cf_in;
            df_ff     <= df_in;
            if_ff     <= if_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            rf_valid_ff[s1_ff.reg_number] <= 1'b1;
            fwd_valid_ff                  <= 1'b1;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= s1_in;
         rd_addr_ff <= rd_addr;
      end
      if (s1_adv) begin
         out_ff       <= s1_ff;
         out_value_ff <= s1_ff.reg_written ? new_value : '0;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_ff.reg_number;
         fwd_data_ff <= new_value;
      end
   end

   // ------------------------------------------------------------------------
   // Result channel.
   // ------------------------------------------------------------------------
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_ff.status;
   assign rsp_bus.instr_len      = out_ff.instr_len;
   assign rsp_bus.reg_written    = out_ff.reg_written;
   assign rsp_bus.reg_number     = out_ff.reg_number;
   assign rsp_bus.reg_value      = out_value_ff;
   assign rsp_bus.carry_flag     = out_ff.carry_flag;
   assign rsp_bus.direction_flag = out_ff.direction_flag;
   assign rsp_bus.interrupt_flag = out_ff.interrupt_flag;
   assign rsp_bus.cpuid_request  = out_ff.cpuid_request;

endmodule

FILE: rtl/xbd_ram.sv
// ============================================================================
// xbd_ram
// Generic RAM with one write port and one read port, registered read data.
// ============================================================================
module xbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/xbd_checker.sv
// ============================================================================
// xbd_checker
// Port-level checks on the decoder result channel.
// ============================================================================
module xbd_checker
   import xbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [4:0]  rsp_instr_len,
   input  logic        rsp_reg_written,
   input  logic [2:0]  rsp_reg_number,
   input  logic [31:0] rsp_reg_value,
   input  logic        rsp_cpuid_request
);

   // A stalled result keeps its register write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg_value)
         && $stable(rsp_reg_number) && $stable(rsp_status))
      else $error("stalled result changed");

   // Only a finished instruction reports a length, and it is within the limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_DONE) ?
         (rsp_instr_len != 5'd0 && rsp_instr_len <= 5'(MAX_INSTR_BYTES)) :
         (rsp_instr_len == 5'd0)))
      else $error("instruction length does not match status");

   // A register write or a cpuid request only comes with a finished instruction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_reg_written || rsp_cpuid_request) |-> rsp_status == ST_DONE
         && !(rsp_reg_written && rsp_cpuid_request))
      else $error("register write or cpuid without completed instruction");

   // Without a register write the register fields are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_written |-> rsp_reg_number == 3'd0 && rsp_reg_value == 32'd0)
      else $error("register fields set without a write");

endmodule

bind x86_subset_byte_decoder_top xbd_checker u_xbd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_instr_len     (rsp_bus.instr_len),
   .rsp_reg_written   (rsp_bus.reg_written),
   .rsp_reg_number    (rsp_bus.reg_number),
   .rsp_reg_value     (rsp_bus.reg_value),
   .rsp_cpuid_request (rsp_bus.cpuid_request)
);
